>>> design/cpd_pkg.sv
// cpd_pkg: shared types and constants for the crc16 packet deframer
// no dependencies; imported by cpd_crc8, crc16_packet_deframer, frame_scoreboard_pkg and the bench
package cpd_pkg;

    // frame marker bytes
    localparam logic [7:0]  START_BYTE  = 8'h21;
    localparam logic [7:0]  SYNC_BYTE   = 8'h24;
    localparam logic [15:0] CRC_TOP_BIT = 16'h8000;

    // configuration register indexes
    localparam logic [0:0] REG_CRC_POLY = 1'b0;
    localparam logic [0:0] REG_CRC_INIT = 1'b1;

    // reset values of the configuration registers
    localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
    localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

    // parser phase
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC,
        PH_LENGTH,
        PH_DEVICE,
        PH_MESSAGE,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    // kind of result transaction
    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_GOOD,
        KIND_BAD
    } kind_t;

endpackage

>>> design/cpd_crc8.sv
// cpd_crc8: msb-first crc-16 update over one byte, unrolled over its 8 bits
// depends on cpd_pkg
module cpd_crc8
    import cpd_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    input  logic [15:0] poly,
    output logic [15:0] crc_out
);

    // one shift-and-conditional-xor per data bit
    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP_BIT) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

>>> design/crc16_packet_deframer.sv
// crc16_packet_deframer: byte-stream frame parser with crc-16 check
// an accepted input byte is held in the input register, and its result is loaded into the output register
// throughput: one byte per cycle while no result is stalled at the output, set by the single-byte unrolled crc update
// bytes that yield no result (header, crc low byte, hunting) still take one slot
// reset: synchronous active-low aresetn clears parser state, pipeline valids and
// loads the crc registers with 0x1021 / 0xFFFF
module crc16_packet_deframer
    import cpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] payload_data, [15:8] payload_index,
                                   // [23:16] frame_length, [31:24] source_device,
                                   // [39:32] message_type
    output logic [1:0]  m_tuser    // [1:0] item_kind
);

    // configuration registers
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_init_reg;

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  device_reg, device_next;
    logic [7:0]  message_reg, message_next;
    logic [7:0]  seen_reg, seen_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    // output stage
    logic        out_valid_reg;
    kind_t       out_kind_reg, out_kind_next;
    logic [39:0] out_data_reg, out_data_next;
    logic        emit;

    logic        advance;
    logic        payload_done;
    logic [15:0] crc_base;
    logic [15:0] crc_fed;
    logic [15:0] crc_got;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_poly_reg <= CRC_POLY_RESET;
            crc_init_reg <= CRC_INIT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CRC_POLY: crc_poly_reg <= cfg_wdata;
                REG_CRC_INIT: crc_init_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake: the input stage refills whenever its byte moves on
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // crc update for the current byte
    assign crc_base = (phase_reg == PH_HUNT) ? crc_init_reg : crc_reg;

    cpd_crc8 u_crc8 (
        .crc_in  (crc_base),
        .data_in (in_byte_reg),
        .poly    (crc_poly_reg),
        .crc_out (crc_fed)
    );

    assign payload_done = ({1'b0, seen_reg} + 9'd1) >= {1'b0, length_reg};
    assign crc_got      = {in_byte_reg, crc_lo_reg};

    // next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT:    if (in_byte_reg == START_BYTE) begin
                phase_next = PH_SYNC;
            end
            PH_SYNC:    phase_next = (in_byte_reg == SYNC_BYTE) ? PH_LENGTH : PH_HUNT;
            PH_LENGTH:  phase_next = PH_DEVICE;
            PH_DEVICE:  phase_next = PH_MESSAGE;
            PH_MESSAGE: phase_next = (length_reg == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
            PH_PAYLOAD: if (payload_done) begin
                phase_next = PH_CRC_LO;
            end
            PH_CRC_LO:  phase_next = PH_CRC_HI;
            PH_CRC_HI:  phase_next = PH_HUNT;
            default:    phase_next = PH_HUNT;
        endcase
    end

    // datapath and result
    always_comb begin
        crc_next      = crc_reg;
        length_next   = length_reg;
        device_next   = device_reg;
        message_next  = message_reg;
        seen_next     = seen_reg;
        crc_lo_next   = crc_lo_reg;
        emit          = 1'b0;
        out_kind_next = KIND_PAYLOAD;
        out_data_next = {message_reg, device_reg, length_reg, 16'h0000};
        case (phase_reg)
            PH_HUNT: begin
                if (in_byte_reg == START_BYTE) begin
                    crc_next     = crc_fed;
                    length_next  = 8'h00;
                    device_next  = 8'h00;
                    message_next = 8'h00;
                    seen_next    = 8'h00;
                    crc_lo_next  = 8'h00;
                end
            end
            PH_SYNC: begin
                if (in_byte_reg == SYNC_BYTE) begin
                    crc_next = crc_fed;
                end
            end
            PH_LENGTH: begin
                crc_next    = crc_fed;
                length_next = in_byte_reg;
            end
            PH_DEVICE: begin
                crc_next    = crc_fed;
                device_next = in_byte_reg;
            end
            PH_MESSAGE: begin
                crc_next     = crc_fed;
                message_next = in_byte_reg;
                seen_next    = 8'h00;
            end
            PH_PAYLOAD: begin
                crc_next      = crc_fed;
                seen_next     = seen_reg + 8'd1;
                emit          = 1'b1;
                out_kind_next = KIND_PAYLOAD;
                out_data_next = {message_reg, device_reg, length_reg, seen_reg, in_byte_reg};
            end
            PH_CRC_LO: begin
                crc_lo_next = in_byte_reg;
            end
            PH_CRC_HI: begin
                emit          = 1'b1;
                out_kind_next = (crc_got == crc_reg) ? KIND_GOOD : KIND_BAD;
            end
            default: ;
        endcase
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            crc_reg     <= 16'h0000;
            length_reg  <= 8'h00;
            device_reg  <= 8'h00;
            message_reg <= 8'h00;
            seen_reg    <= 8'h00;
            crc_lo_reg  <= 8'h00;
        end else if (advance) begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            length_reg  <= length_next;
            device_reg  <= device_next;
            message_reg <= message_next;
            seen_reg    <= seen_next;
            crc_lo_reg  <= crc_lo_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

`ifndef SYNTHESIS
    // the crc high byte always yields a frame-end transaction
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase_reg == PH_CRC_HI) |=>
            (out_valid_reg && out_kind_reg != KIND_PAYLOAD))
        else $error("crc high byte did not produce a frame-end transaction");

    // the last payload byte moves the parser to the crc low byte
    a_payload_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase_reg == PH_PAYLOAD && payload_done) |=> (phase_reg == PH_CRC_LO))
        else $error("parser did not leave payload after the last byte");

    // a stalled input stage keeps its byte
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input stage lost a byte while stalled");

    // a pending result is not overwritten while the output is stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("parser advanced over a pending result");
`endif

endmodule

>>> tb/sv/frame_scoreboard_pkg.sv
`timescale 1ns / 100ps
// frame_scoreboard_pkg: frame parser prediction and result checking for the deframer bench
// depends on cpd_pkg for the phase and kind enums, marker bytes and register reset values
package frame_scoreboard_pkg;
    import cpd_pkg::*;

    // one expected result transaction
    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] length;
        logic [7:0] device;
        logic [7:0] message;
    } frame_item_t;

    class frame_scoreboard;
        // register copies
        logic [15:0] poly;
        logic [15:0] init;
        // parser copy
        phase_t      phase;
        logic [15:0] crc;
        logic [7:0]  length;
        logic [7:0]  device;
        logic [7:0]  message;
        logic [7:0]  payload_count;
        logic [7:0]  crc_lo;
        frame_item_t expected_items[$];
        int          errors;

        function new();
            poly          = CRC_POLY_RESET;
            init          = CRC_INIT_RESET;
            phase         = PH_HUNT;
            crc           = '0;
            length        = '0;
            device        = '0;
            message       = '0;
            payload_count = '0;
            crc_lo        = '0;
            errors        = 0;
        endfunction

        function void write_reg(logic [0:0] addr, logic [15:0] value);
            if (addr == REG_CRC_POLY) begin
                poly = value;
            end else begin
                init = value;
            end
        endfunction

        // msb-first crc over one byte, top bit of the polynomial implicit
        function logic [15:0] crc_update(logic [15:0] value, logic [7:0] b);
            logic [15:0] c;
            c = value ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) begin
                c = c[15] ? ((c << 1) ^ poly) : (c << 1);
            end
            return c;
        endfunction

        function void push_item(kind_t kind, logic [7:0] data, logic [7:0] index);
            frame_item_t item;
            item.kind    = kind;
            item.data    = data;
            item.index   = index;
            item.length  = length;
            item.device  = device;
            item.message = message;
            expected_items.push_back(item);
        endfunction

        // advance the parser by one accepted input byte
        function void note_rx_byte(logic [7:0] b);
            case (phase)
                PH_HUNT: begin
                    if (b == START_BYTE) begin
                        crc           = crc_update(init, b);
                        length        = '0;
                        device        = '0;
                        message       = '0;
                        payload_count = '0;
                        crc_lo        = '0;
                        phase         = PH_SYNC;
                    end
                end
                PH_SYNC: begin
                    // anything but the sync byte is dropped, even a new start byte
                    if (b == SYNC_BYTE) begin
                        crc   = crc_update(crc, b);
                        phase = PH_LENGTH;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
                PH_LENGTH: begin
                    crc    = crc_update(crc, b);
                    length = b;
                    phase  = PH_DEVICE;
                end
                PH_DEVICE: begin
                    crc    = crc_update(crc, b);
                    device = b;
                    phase  = PH_MESSAGE;
                end
                PH_MESSAGE: begin
                    crc           = crc_update(crc, b);
                    message       = b;
                    payload_count = '0;
                    phase         = (length == 0) ? PH_CRC_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    crc = crc_update(crc, b);
                    push_item(KIND_PAYLOAD, b, payload_count);
                    payload_count++;
                    if (payload_count >= length) phase = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    crc_lo = b;
                    phase  = PH_CRC_HI;
                end
                default: begin
                    push_item(({b, crc_lo} == crc) ? KIND_GOOD : KIND_BAD, 8'h00, 8'h00);
                    phase = PH_HUNT;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // compare one accepted result transaction with the oldest expectation
        function void check_item(logic [1:0] kind, logic [39:0] data);
            frame_item_t want;
            if (expected_items.size() == 0) begin
                $error("result with no expectation: kind %0d, data %0h", kind, data);
                errors++;
                return;
            end
            want = expected_items.pop_front();
            compare_field("item_kind", 8'(want.kind), {6'b0, kind});
            compare_field("payload_data", want.data, data[7:0]);
            compare_field("payload_index", want.index, data[15:8]);
            compare_field("frame_length", want.length, data[23:16]);
            compare_field("source_device", want.device, data[31:24]);
            compare_field("message_type", want.message, data[39:32]);
        endfunction

        function int pending();
            return expected_items.size();
        endfunction
    endclass

endpackage

>>> tb/sv/crc16_packet_deframer_tb.sv
`timescale 1ns / 100ps
// crc16_packet_deframer_tb: byte-stream bench for the crc16 packet deframer
// depends on cpd_pkg, frame_scoreboard_pkg and the crc16_packet_deframer rtl
module crc16_packet_deframer_tb
    import cpd_pkg::*;
    import frame_scoreboard_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 100;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    frame_scoreboard sb = new();
    bit tx_gaps   = 1'b0;
    bit rx_stalls = 1'b0;
    bit hold_long = 1'b0;
    int bytes_sent  = 0;
    int idle_cycles = 0;

    crc16_packet_deframer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // transaction monitor on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_rx_byte(s_tdata);
            if (m_tvalid && m_tready) sb.check_item(m_tuser, m_tdata);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result receiver: random stall bursts and one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_long = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // offer one byte, optionally after a gap, and wait for its transaction
    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // build a frame with the current crc settings; corrupt flips one crc bit
    task automatic send_frame(input int len, input logic [7:0] dev, input logic [7:0] msg,
                              input bit corrupt);
        logic [7:0]  frame_q[$];
        logic [15:0] crc;
        frame_q = '{START_BYTE, SYNC_BYTE, 8'(len), dev, msg};
        repeat (len) frame_q.push_back(8'($urandom));
        crc = sb.init;
        foreach (frame_q[i]) crc = sb.crc_update(crc, frame_q[i]);
        if (corrupt) crc ^= 16'(1) << $urandom_range(0, 15);
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
        foreach (frame_q[i]) send_byte(frame_q[i]);
    endtask

    // stop offering and let every expected result and the pipeline drain
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // write both crc registers back to back, only while the block is idle
    task automatic configure(input logic [15:0] poly, input logic [15:0] init);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_CRC_POLY;
        cfg_wdata <= poly;
        @(negedge aclk);
        cfg_addr  <= REG_CRC_INIT;
        cfg_wdata <= init;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(REG_CRC_POLY, poly);
        sb.write_reg(REG_CRC_INIT, init);
        @(negedge aclk);
    endtask

    // mostly well-formed frames, plus line noise and broken headers
    task automatic run_random(input int count);
        int         stop_at;
        int         pick;
        int         len;
        logic [7:0] b;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (pick < 12) begin
                // start byte followed by a wrong sync byte
                b = 8'($urandom);
                if (b == SYNC_BYTE) b = 8'h00;
                send_byte(START_BYTE);
                send_byte(b);
            end else if (pick < 14) begin
                // header cut short, next frame lands in its body
                send_byte(START_BYTE);
                send_byte(SYNC_BYTE);
                send_byte(8'($urandom_range(0, 6)));
            end else begin
                len = ($urandom_range(0, 59) == 0) ? 255 : $urandom_range(0, 12);
                send_frame(len, 8'($urandom), 8'($urandom), $urandom_range(0, 4) == 0);
            end
        end
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: noise while hunting, dropped start byte, zero length, bad crc
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_BYTE);
        send_byte(START_BYTE);
        send_byte(SYNC_BYTE);
        send_frame(0, 8'hFF, 8'h00, 1'b0);
        send_frame(1, 8'h00, 8'hFF, 1'b1);
        wait_drained();

        // default crc settings with idling on both sides, one longest frame
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_frame(255, 8'($urandom), 8'($urandom), 1'b0);
        run_random(100);
        wait_drained();

        configure(16'h8005, 16'h0000);
        tx_gaps = 1'b0;
        run_random(60);
        wait_drained();

        configure(16'hFFFF, 16'hFFFF);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b0;
        run_random(40);
        wait_drained();

        configure(16'h0000, 16'h0000);
        rx_stalls = 1'b1;
        run_random(40);
        wait_drained();

        // receiver holds off while the sender keeps offering back to back
        configure(16'($urandom), 16'($urandom));
        tx_gaps   = 1'b0;
        hold_long = 1'b1;
        repeat (4) send_frame(20, 8'($urandom), 8'($urandom), 1'b0);
        tx_gaps = 1'b1;
        run_random(30);
        wait_drained();

        // last part without any idling
        configure(CRC_POLY_RESET, CRC_INIT_RESET);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        run_random(60);
        wait_drained();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
